// File: sv/srrw_pkg.sv
// Types and constants shared by the selective repeat receive window modules.
package srrw_pkg;

	localparam logic [31:0] TYPE_START = 32'd0;
	localparam logic [31:0] TYPE_END   = 32'd1;
	localparam logic [31:0] TYPE_DATA  = 32'd2;

	localparam logic [1:0] KIND_ACK     = 2'd0;
	localparam logic [1:0] KIND_STORE   = 2'd1;
	localparam logic [1:0] KIND_DELIVER = 2'd2;
	localparam logic [1:0] KIND_ERROR   = 2'd3;

	typedef struct packed {
		logic [31:0] pkt_type;
		logic [31:0] seq_value;
		logic [10:0] payload_len;
		logic [31:0] hdr_checksum;
		logic [31:0] payload_crc;
		logic        truncated;
	} pkt_t;

	typedef struct packed {
		logic [1:0]  out_kind;
		logic [31:0] out_seq;
		logic [3:0]  slot_index;
		logic [15:0] conn_number;
		logic        last;
	} res_t;

	// Classified packet handed from front to back.
	typedef struct packed {
		logic        start_ok;
		logic        drop;
		logic        is_end;
		logic [31:0] seq;
	} cmd_t;

	typedef enum logic [0:0] {
		BK_IDLE,
		BK_DRAIN
	} back_state_t;

endpackage

// File: sv/selective_repeat_receive_window.sv
// Path: a packet word is registered by the front, queued, then handled by the back,
// which registers each result word before it reaches the outputs.
// Results: a dropped packet gives none, other single-result packets one word, and an
// in-window data packet a store, each delivery, then an ack (up to WINDOW + 2 words).
// The back takes no new packet until that ack; a two-entry queue keeps the front accepting.
// Reset (arst_n low) clears connection state, window map, counters and all valids.
module selective_repeat_receive_window import srrw_pkg::*; #(
	parameter int WINDOW = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic pkt_valid,
	output logic pkt_stall,
	input  pkt_t pkt,
	output logic res_valid,
	input  logic res_stall,
	output res_t res
);

	// front to queue
	logic front_valid;
	cmd_t front_cmd;
	logic queue_full;

	// queue to back
	logic head_valid;
	cmd_t head_cmd;
	logic head_pop;

	// Classify each word: start check, drop reasons, end marker.
	srrw_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.pkt_valid (pkt_valid),
		.pkt_stall (pkt_stall),
		.pkt       (pkt),
		.cmd_valid (front_valid),
		.cmd_full  (queue_full),
		.cmd       (front_cmd)
	);

	// Hold classified commands while the back is busy draining the window or its output stalls.
	srrw_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (front_valid),
		.push_cmd   (front_cmd),
		.full       (queue_full),
		.pop        (head_pop),
		.head_valid (head_valid),
		.head_cmd   (head_cmd)
	);

	// Apply commands to the window and emit result words one per cycle while the output is not stalled.
	srrw_back #(
		.WINDOW (WINDOW)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (head_valid),
		.cmd       (head_cmd),
		.cmd_pop   (head_pop),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

endmodule

// File: sv/srrw_front.sv
// Front stage: reduces each packet word to a classified command and registers it.
module srrw_front import srrw_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic pkt_valid,
	output logic pkt_stall,
	input  pkt_t pkt,
	output logic cmd_valid,
	input  logic cmd_full,
	output cmd_t cmd
);

	logic valid_s1;
	cmd_t cmd_s1;
	cmd_t cmd_d;
	logic long_pkt;

	assign pkt_stall = valid_s1 && cmd_full;
	assign cmd_valid = valid_s1;
	assign cmd = cmd_s1;

	always_comb begin
		long_pkt = (pkt.payload_len != 11'd0);
		cmd_d.start_ok = (pkt.pkt_type == TYPE_START) && !long_pkt;
		cmd_d.is_end = (pkt.pkt_type == TYPE_END);
		// drop while connected: truncated, stray type, or corrupt data
		cmd_d.drop = (pkt.truncated && long_pkt)
			|| ((pkt.pkt_type != TYPE_END) && (pkt.pkt_type != TYPE_DATA))
			|| ((pkt.pkt_type == TYPE_DATA) && long_pkt
				&& (pkt.payload_crc != pkt.hdr_checksum));
		cmd_d.seq = pkt.seq_value;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!pkt_stall) begin
			valid_s1 <= pkt_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!pkt_stall && pkt_valid) begin
			cmd_s1 <= cmd_d;
		end
	end

endmodule

// File: sv/srrw_queue.sv
// Two-entry command queue between front and back.
module srrw_queue import srrw_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic head_valid,
	output cmd_t head_cmd
);

	cmd_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push;
	logic       do_pop;

	assign full = (count_q == 2'd2);
	assign head_valid = (count_q != 2'd0);
	assign head_cmd = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

// File: sv/srrw_back.sv
// Back end: connection state, receive window and result sequencing.
module srrw_back import srrw_pkg::*; #(
	parameter int WINDOW = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	input  cmd_t cmd,
	output logic cmd_pop,
	output logic res_valid,
	input  logic res_stall,
	output res_t res
);

	localparam int SW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam logic [SW:0]   WIN_SUM   = (SW + 1)'(WINDOW);
	localparam logic [31:0]   WIN32     = 32'(WINDOW);
	localparam logic [SW-1:0] HEAD_LAST = SW'(WINDOW - 1);

	back_state_t       state_q, state_d;
	logic              connected_q, connected_d;
	logic [31:0]       start_seq_q, start_seq_d;
	logic [31:0]       base_seq_q, base_seq_d;
	logic [WINDOW-1:0] present_q, present_d;
	logic [SW-1:0]     head_q, head_d;
	logic [15:0]       conn_q, conn_d;

	logic       res_valid_q;
	res_t       res_q;
	logic       can_emit;
	logic       emit;
	logic [1:0] e_kind;
	logic [31:0] e_seq;
	logic [3:0] e_slot;
	logic       e_last;

	logic [31:0] off;
	logic        old;
	logic        in_win;
	logic [SW:0] sum;
	logic [SW-1:0] slot;
	logic [31:0] slot_ext;
	logic [31:0] head_ext;

	assign res_valid = res_valid_q;
	assign res = res_q;
	assign can_emit = !res_valid_q || !res_stall;

	always_comb begin
		off = cmd.seq - base_seq_q;
		old = cmd.seq < base_seq_q;
		in_win = !old && (off < WIN32);
		sum = {1'b0, head_q} + {1'b0, off[SW-1:0]};
		slot = (sum >= WIN_SUM) ? SW'(sum - WIN_SUM) : sum[SW-1:0];
		slot_ext = 32'(slot);
		head_ext = 32'(head_q);
	end

	always_comb begin
		state_d = state_q;
		connected_d = connected_q;
		start_seq_d = start_seq_q;
		base_seq_d = base_seq_q;
		present_d = present_q;
		head_d = head_q;
		conn_d = conn_q;
		cmd_pop = 1'b0;
		emit = 1'b0;
		e_kind = KIND_ACK;
		e_seq = 32'd0;
		e_slot = 4'd0;
		e_last = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (cmd_valid) begin
					if (!connected_q) begin
						if (can_emit) begin
							emit = 1'b1;
							cmd_pop = 1'b1;
							e_last = 1'b1;
							if (cmd.start_ok) begin
								e_kind = KIND_ACK;
								e_seq = cmd.seq;
								start_seq_d = cmd.seq;
								connected_d = 1'b1;
							end else begin
								e_kind = KIND_ERROR;
							end
						end
					end else if (cmd.drop) begin
						cmd_pop = 1'b1;
					end else if (cmd.is_end) begin
						if (cmd.seq == start_seq_q) begin
							if (can_emit) begin
								emit = 1'b1;
								cmd_pop = 1'b1;
								e_kind = KIND_ACK;
								e_seq = start_seq_q;
								e_last = 1'b1;
								conn_d = conn_q + 16'd1;
								connected_d = 1'b0;
								present_d = '0;
								head_d = '0;
								base_seq_d = 32'd0;
							end
						end else begin
							cmd_pop = 1'b1;
						end
					end else if (old) begin
						if (can_emit) begin
							emit = 1'b1;
							cmd_pop = 1'b1;
							e_kind = KIND_ACK;
							e_seq = base_seq_q;
							e_last = 1'b1;
						end
					end else if (in_win) begin
						if (can_emit) begin
							emit = 1'b1;
							cmd_pop = 1'b1;
							e_kind = KIND_STORE;
							e_seq = cmd.seq;
							e_slot = slot_ext[3:0];
							present_d[slot] = 1'b1;
							state_d = BK_DRAIN;
						end
					end else begin
						cmd_pop = 1'b1;
					end
				end
			end
			BK_DRAIN: begin
				if (can_emit) begin
					emit = 1'b1;
					if (present_q[head_q]) begin
						e_kind = KIND_DELIVER;
						e_seq = base_seq_q;
						e_slot = head_ext[3:0];
						present_d[head_q] = 1'b0;
						head_d = (head_q == HEAD_LAST) ? '0 : head_q + SW'(1);
						base_seq_d = base_seq_q + 32'd1;
					end else begin
						e_kind = KIND_ACK;
						e_seq = base_seq_q;
						e_last = 1'b1;
						state_d = BK_IDLE;
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			connected_q <= 1'b0;
			start_seq_q <= 32'd0;
			base_seq_q <= 32'd0;
			present_q <= '0;
			head_q <= '0;
			conn_q <= 16'd0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			connected_q <= connected_d;
			start_seq_q <= start_seq_d;
			base_seq_q <= base_seq_d;
			present_q <= present_d;
			head_q <= head_d;
			conn_q <= conn_d;
			if (emit) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_q.out_kind <= e_kind;
			res_q.out_seq <= e_seq;
			res_q.slot_index <= e_slot;
			res_q.conn_number <= conn_q;
			res_q.last <= e_last;
		end
	end

endmodule

// File: sv/srrw_checker.sv
// Port checks for the receive window, bound to the top level.
module srrw_checker import srrw_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic res_valid,
	input logic res_stall,
	input res_t res
);

	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !res_valid)
		else $error("result valid during reset");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("stalled result word changed");

	a_error_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res.out_kind == KIND_ERROR) |->
			res.last && (res.out_seq == 32'd0) && (res.slot_index == 4'd0))
		else $error("start error word malformed");

	a_store_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && ((res.out_kind == KIND_STORE) || (res.out_kind == KIND_DELIVER))
			|-> !res.last)
		else $error("store or deliver word marked last");

	a_ack_slot: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res.out_kind == KIND_ACK) |-> (res.slot_index == 4'd0))
		else $error("ack word carries a slot");

endmodule

bind selective_repeat_receive_window srrw_checker u_srrw_checker (.*);

// File: dv/tb_top.sv
// Testbench for the selective repeat receive window: directed and random packet words.
module tb_top;
	import srrw_pkg::*;

	localparam int WIN          = 16;
	localparam int RANDOM_ITEMS = 112;   // random words on top of the directed ones
	localparam int HOLD_CYCLES  = 400;   // long receiver hold-off for the back-pressure test
	localparam int QUIET_LIMIT  = 4000;  // cycles with no word moving on either side
	localparam int DRAIN_CYCLES = 24;    // front latency plus a full in-order drain
	localparam int EXP_DEPTH    = 512;   // room for expected result words in flight

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic pkt_valid = 1'b0;
	logic pkt_stall;
	pkt_t pkt = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	res_t res;

	// Mirror of the receive window, advanced once per accepted packet word
	logic           link_up = 1'b0;
	logic [31:0]    open_seq = '0;
	logic [31:0]    expect_seq = '0;
	logic [WIN-1:0] present_bits = '0;
	logic [3:0]     head = '0;
	logic [15:0]    conn_cnt = '0;

	// Expected result words, written at exp_wr and consumed at exp_rd
	res_t exp_fifo[EXP_DEPTH];
	int   exp_wr = 0;
	int   exp_rd = 0;
	int   mismatches = 0;
	int   quiet_cycles = 0;
	bit   hold_flip = 1'b0;   // toggle to ask the receiver for one long hold-off

	selective_repeat_receive_window #(.WINDOW(WIN)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.pkt_valid(pkt_valid),
		.pkt_stall(pkt_stall),
		.pkt(pkt),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Window predictor
	// ------------------------------------------------------------------
	function automatic res_t make_result(logic [1:0] kind, logic [31:0] seq, logic [3:0] slot);
		res_t r;
		r.out_kind    = kind;
		r.out_seq     = seq;
		r.slot_index  = slot;
		r.conn_number = conn_cnt;
		r.last        = 1'b0;
		return r;
	endfunction

	// Work out every result that one accepted packet word causes and queue them in order.
	function automatic void predict_window(pkt_t p);
		res_t        batch[WIN+2];
		int          nb;
		res_t        r;
		logic [31:0] offset;
		logic [3:0]  slot;
		nb = 0;
		if (!link_up) begin
			// Idle: only a zero-length start opens a connection; the cut flag is ignored
			if (p.pkt_type == TYPE_START && p.payload_len == 11'd0) begin
				open_seq = p.seq_value;
				batch[nb] = make_result(KIND_ACK, open_seq, 4'd0);
				nb++;
				link_up = 1'b1;
			end else begin
				batch[nb] = make_result(KIND_ERROR, 32'd0, 4'd0);
				nb++;
			end
		end else if (p.truncated && p.payload_len != 11'd0) begin
			// drop a cut-short payload whatever its type
		end else if (p.pkt_type == TYPE_END && p.seq_value == open_seq) begin
			// Ack carries the closing connection number, then clear the window
			batch[nb] = make_result(KIND_ACK, open_seq, 4'd0);
			nb++;
			conn_cnt     = conn_cnt + 16'd1;
			link_up      = 1'b0;
			present_bits = '0;
			head         = '0;
			expect_seq   = '0;
		end else if (p.pkt_type == TYPE_DATA &&
				!(p.payload_len != 11'd0 && p.payload_crc != p.hdr_checksum)) begin
			offset = p.seq_value - expect_seq;
			if (p.seq_value < expect_seq) begin
				batch[nb] = make_result(KIND_ACK, expect_seq, 4'd0);
				nb++;
			end else if (offset < 32'(WIN)) begin
				slot = head + offset[3:0];
				present_bits[slot] = 1'b1;
				batch[nb] = make_result(KIND_STORE, p.seq_value, slot);
				nb++;
				// Deliver every in-order slot, then ack the next expected number
				while (present_bits[head]) begin
					batch[nb] = make_result(KIND_DELIVER, expect_seq, head);
					nb++;
					present_bits[head] = 1'b0;
					head       = head + 4'd1;
					expect_seq = expect_seq + 32'd1;
				end
				batch[nb] = make_result(KIND_ACK, expect_seq, 4'd0);
				nb++;
			end
		end
		for (int i = 0; i < nb; i++) begin
			r = batch[i];
			r.last = (i == nb - 1);
			exp_fifo[exp_wr % EXP_DEPTH] = r;
			exp_wr++;
		end
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	function automatic pkt_t make_pkt(logic [31:0] kind, logic [31:0] seq, logic [10:0] len,
			bit crc_ok, bit cut);
		pkt_t p;
		p.pkt_type     = kind;
		p.seq_value    = seq;
		p.payload_len  = len;
		p.hdr_checksum = $urandom();
		p.payload_crc  = crc_ok ? p.hdr_checksum : (p.hdr_checksum ^ ($urandom() | 32'd1));
		p.truncated    = cut;
		return p;
	endfunction

	function automatic logic [10:0] rand_len();
		return ($urandom_range(0, 6) == 0) ? 11'd0 : 11'($urandom_range(1, 1456));
	endfunction

	// Offer one packet word and hold it until accepted, then advance the predictor.
	// Valid is left high: the caller lowers it only when it means to leave a gap.
	task automatic send_packet(input pkt_t p);
		pkt       <= p;
		pkt_valid <= 1'b1;
		do @(posedge clk); while (pkt_stall !== 1'b0);
		predict_window(p);
	endtask

	// Pause the sender until every expected result has come back, then let the back settle.
	task automatic wait_drained();
		pkt_valid <= 1'b0;
		wait (exp_wr == exp_rd);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	// Idle block: everything but a zero-length start is a start error.
	task automatic test_idle_errors();
		send_packet(make_pkt(TYPE_DATA, 32'd0, 11'd0, 1'b1, 1'b0));
		send_packet(make_pkt(TYPE_START, 32'h1234_5678, 11'd1456, 1'b1, 1'b0));
		send_packet(make_pkt(TYPE_END, 32'd0, 11'd0, 1'b1, 1'b0));
		send_packet(make_pkt(32'hFFFF_FFFF, 32'hFFFF_FFFF, 11'd0, 1'b0, 1'b1));
		// a cut flag on a zero-length start must not stop it opening
		send_packet(make_pkt(TYPE_START, 32'hFFFF_FFF0, 11'd0, 1'b0, 1'b1));
	endtask

	// Connected block: reordering, old, far-ahead, corrupt, cut and stray words, then close.
	task automatic test_window_cases();
		send_packet(make_pkt(TYPE_DATA, 32'd1, 11'd200, 1'b1, 1'b0));     // stored out of order
		send_packet(make_pkt(TYPE_DATA, 32'd0, 11'd1456, 1'b1, 1'b0));    // drains two slots
		send_packet(make_pkt(TYPE_DATA, 32'd0, 11'd64, 1'b1, 1'b0));      // old: re-ack
		send_packet(make_pkt(TYPE_DATA, 32'd18, 11'd64, 1'b1, 1'b0));     // one past window
		send_packet(make_pkt(TYPE_DATA, 32'd17, 11'd64, 1'b1, 1'b0));     // top of window
		send_packet(make_pkt(TYPE_DATA, 32'd17, 11'd64, 1'b1, 1'b0));     // duplicate
		send_packet(make_pkt(TYPE_DATA, 32'd3, 11'd64, 1'b0, 1'b0));      // corrupt
		send_packet(make_pkt(TYPE_DATA, 32'd3, 11'd100, 1'b1, 1'b1));     // cut short
		send_packet(make_pkt(TYPE_DATA, 32'd2, 11'd0, 1'b0, 1'b1));       // zero length counts
		send_packet(make_pkt(TYPE_END, 32'hFFFF_FFF1, 11'd0, 1'b1, 1'b0)); // wrong end number
		send_packet(make_pkt(TYPE_START, 32'd5, 11'd0, 1'b1, 1'b0));      // stray start
		send_packet(make_pkt(32'd7, 32'd3, 11'd0, 1'b1, 1'b0));           // unknown type
		send_packet(make_pkt(TYPE_DATA, 32'hFFFF_FFFF, 11'd1, 1'b1, 1'b0)); // far ahead
		send_packet(make_pkt(TYPE_END, 32'hFFFF_FFF0, 11'd9, 1'b1, 1'b1)); // cut end dropped
		send_packet(make_pkt(TYPE_END, 32'hFFFF_FFF0, 11'd0, 1'b1, 1'b0)); // close
	endtask

	// Hold the receiver off while a full window arrives in random order, so the block
	// fills and stalls its input; the last word then drains all slots at once.
	task automatic test_backpressure();
		int order[WIN-1];
		int j, tmp;
		for (int i = 0; i < WIN - 1; i++)
			order[i] = i + 1;
		for (int i = WIN - 2; i > 0; i--) begin
			j = $urandom_range(0, i);
			tmp = order[i];
			order[i] = order[j];
			order[j] = tmp;
		end
		send_packet(make_pkt(TYPE_START, $urandom(), 11'd0, 1'b1, 1'b0));
		hold_flip = ~hold_flip;
		for (int i = 0; i < WIN - 1; i++)
			send_packet(make_pkt(TYPE_DATA, 32'(order[i]), rand_len(), 1'b1, 1'b0));
		send_packet(make_pkt(TYPE_DATA, 32'd0, rand_len(), 1'b1, 1'b0));
		wait_drained();
		send_packet(make_pkt(TYPE_END, open_seq, 11'd0, 1'b1, 1'b0));
	endtask

	// Mostly well-formed connections with random content, plus noise and broken words.
	task automatic test_random_traffic();
		int          sent, burst_left, gap, pick, back;
		logic [31:0] seq;
		pkt_t        p;
		sent       = 0;
		burst_left = 0;
		while (sent < RANDOM_ITEMS) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 12);
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				if (gap > 0) begin
					pkt_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			burst_left--;
			pick = $urandom_range(0, 99);
			if (!link_up) begin
				if (pick < 80)
					p = make_pkt(TYPE_START, $urandom(), 11'd0, 1'($urandom_range(0, 1)),
						1'($urandom_range(0, 1)));
				else
					p = make_pkt($urandom(), $urandom(), rand_len(), 1'b1,
						1'($urandom_range(0, 1)));
			end else if (pick < 60 || (pick < 68 && expect_seq == 32'd0)) begin
				seq = expect_seq + 32'($urandom_range(0, WIN - 1));
				p = make_pkt(TYPE_DATA, seq, rand_len(), 1'b1, 1'b0);
			end else if (pick < 68) begin
				back = (expect_seq < 32'd20) ? int'(expect_seq) : 20;
				seq = expect_seq - 32'($urandom_range(1, back));
				p = make_pkt(TYPE_DATA, seq, rand_len(), 1'b1, 1'b0);
			end else if (pick < 74) begin
				seq = $urandom_range(0, 1) ? expect_seq + 32'(WIN + $urandom_range(0, 3))
					: $urandom();
				p = make_pkt(TYPE_DATA, seq, rand_len(), 1'b1, 1'b0);
			end else if (pick < 80) begin
				seq = expect_seq + 32'($urandom_range(0, WIN - 1));
				p = make_pkt(TYPE_DATA, seq, 11'($urandom_range(1, 1456)), 1'b0, 1'b0);
			end else if (pick < 85) begin
				seq = expect_seq + 32'($urandom_range(0, WIN - 1));
				p = make_pkt(TYPE_DATA, seq, rand_len(), 1'b1, 1'b1);
			end else if (pick < 90) begin
				p = make_pkt($urandom(), $urandom(), rand_len(), 1'($urandom_range(0, 1)), 1'b0);
			end else if (pick < 93) begin
				p = make_pkt(TYPE_END, open_seq ^ ($urandom() | 32'd1), 11'd0, 1'b1, 1'b0);
			end else if (pick < 95) begin
				p = make_pkt(TYPE_START, $urandom(), 11'd0, 1'b1, 1'b0);
			end else begin
				p = make_pkt(TYPE_END, open_seq, 11'd0, 1'b1, 1'b0);
			end
			send_packet(p);
			sent++;
		end
	endtask

	// ------------------------------------------------------------------
	// Receiver: own stall pattern, changing every so often, plus the long hold-off
	// ------------------------------------------------------------------
	initial begin : receiver_pattern
		int mode, span, hold_left;
		bit hold_seen;
		mode = 0;
		span = 0;
		hold_left = 0;
		hold_seen = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_flip != hold_seen) begin
				hold_seen = hold_flip;
				hold_left = HOLD_CYCLES;
			end
			if (span == 0) begin
				mode = $urandom_range(0, 3);
				span = $urandom_range(20, 200);
			end
			span--;
			if (hold_left > 0) begin
				hold_left--;
				res_stall <= 1'b1;
			end else begin
				case (mode)
					0: res_stall <= 1'b0;                          // no stalls at all
					1: res_stall <= ($urandom_range(0, 3) == 0);   // light
					2: res_stall <= ($urandom_range(0, 3) != 0);   // heavy
					default: res_stall <= (span % 3 == 0);         // regular beat
				endcase
			end
		end
	end

	// ------------------------------------------------------------------
	// Result checking: compare each accepted result word with the oldest expectation
	// ------------------------------------------------------------------
	task automatic check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
		if (want_v !== got_v) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want_v, got_v);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin : result_check
		res_t want;
		if (arst_n && res_valid === 1'b1 && res_stall === 1'b0) begin
			if (exp_wr == exp_rd) begin
				$display("%0t: unexpected result, expected none, got kind %0d seq %0h", $time,
					res.out_kind, res.out_seq);
				mismatches++;
			end else begin
				want = exp_fifo[exp_rd % EXP_DEPTH];
				exp_rd++;
				check_field("out_kind", 32'(want.out_kind), 32'(res.out_kind));
				check_field("out_seq", want.out_seq, res.out_seq);
				check_field("slot_index", 32'(want.slot_index), 32'(res.slot_index));
				check_field("conn_number", 32'(want.conn_number), 32'(res.conn_number));
				check_field("last", 32'(want.last), 32'(res.last));
			end
		end
	end

	// Watchdog: end the run when no word moves on either side for too long
	always @(posedge clk) begin
		if ((pkt_valid && pkt_stall === 1'b0) || (res_valid === 1'b1 && !res_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: watchdog expired with %0d results outstanding", $time,
				exp_wr - exp_rd);
			$display("Regression FAIL");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Sequence: reset once, run each test in turn, drain, report
	// ------------------------------------------------------------------
	initial begin : run_tests
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_idle_errors();
		test_window_cases();
		test_backpressure();
		test_random_traffic();
		wait_drained();
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// File: selective_repeat_receive_window.f
sv/srrw_pkg.sv
sv/srrw_front.sv
sv/srrw_queue.sv
sv/srrw_back.sv
sv/selective_repeat_receive_window.sv
sv/srrw_checker.sv
dv/tb_top.sv
